// ===== hdl/mwcs_pkg.sv =====
// package: shared types and constants for the memory word change statistics block
`default_nettype none

package mwcs_pkg;

    // sample class carried with each input word
    typedef enum logic [1:0] {
        OP_RESYNC  = 2'd0,
        OP_NEUTRAL = 2'd1,
        OP_LEFT    = 2'd2,
        OP_RIGHT   = 2'd3
    } op_t;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] MIN_NONE  = 16'hFFFF;
    localparam logic [31:0] SUM_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] HALF_TURN = 16'h8000;

    // widest index extension (entry count up to 2^20)
    localparam int unsigned IDX_EXT_W = 21;

    typedef struct packed {
        op_t         op;
        logic [15:0] entry_index;
        logic [15:0] word_value;
    } in_t;

    typedef struct packed {
        logic        changed;
        logic [15:0] neutral_count;
        logic [15:0] left_up_count;
        logic [15:0] left_down_count;
        logic [15:0] right_up_count;
        logic [15:0] right_down_count;
        logic [15:0] left_min_mag;
        logic [15:0] left_max_mag;
        logic [15:0] right_min_mag;
        logic [15:0] right_max_mag;
        logic [31:0] left_mag_total;
        logic [31:0] right_mag_total;
    } out_t;

    // one stored entry of the statistics table
    typedef struct packed {
        logic [15:0] prior;
        logic [15:0] neutral;
        logic [15:0] left_up;
        logic [15:0] left_fall;
        logic [15:0] right_up;
        logic [15:0] right_fall;
        logic [15:0] left_min;
        logic [15:0] left_max;
        logic [15:0] right_min;
        logic [15:0] right_max;
        logic [31:0] left_sum;
        logic [31:0] right_sum;
    } rec_t;

    localparam int unsigned REC_W = $bits(rec_t);

    localparam rec_t REC_RESET = '{
        prior:      16'h0000,
        neutral:    16'h0000,
        left_up:    16'h0000,
        left_fall:  16'h0000,
        right_up:   16'h0000,
        right_fall: 16'h0000,
        left_min:   MIN_NONE,
        left_max:   16'h0000,
        right_min:  MIN_NONE,
        right_max:  16'h0000,
        left_sum:   32'h0000_0000,
        right_sum:  32'h0000_0000
    };

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/mwcs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module mwcs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mwcs_ctrl.sv =====
// controller: clearing pass, word intake and commit sequencing
`default_nettype none

module mwcs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire mwcs_pkg::sts_t sts,
    output mwcs_pkg::cmd_t     cmd
);

    import mwcs_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.commit     = 1'b0;
        item_stall     = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_stall    = 1'b0;
                cmd.load_item = item_valid;
                if (item_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mwcs_datapath.sv =====
// datapath: item register, statistics table, update logic and result register
`default_nettype none

module mwcs_datapath #(
    parameter int unsigned ENTRY_COUNT = 65536
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mwcs_pkg::in_t  item,
    input  wire mwcs_pkg::cmd_t cmd,
    output mwcs_pkg::sts_t      sts,
    output logic                result_valid,
    input  wire logic           result_stall,
    output mwcs_pkg::out_t      result
);

    import mwcs_pkg::*;

    localparam int unsigned AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam logic [IDX_EXT_W-1:0] COUNT_EXT = IDX_EXT_W'(ENTRY_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRY_COUNT - 1);

    in_t              item_reg;
    logic             range_ok_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             out_valid_reg;
    out_t             out_reg;

    logic [IDX_EXT_W-1:0] in_idx_ext;
    logic [IDX_EXT_W-1:0] item_idx_ext;
    logic [AW-1:0]        item_addr;
    logic [REC_W-1:0]     ram_rd_data;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    logic [REC_W-1:0]     ram_wr_data;

    rec_t        rec_old;
    rec_t        rec_new;
    logic        changed;
    logic [15:0] step;
    logic [15:0] mag;
    logic        step_up;
    out_t        out_next;

    function automatic logic [15:0] bump16(input logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? SUM_MAX : s[31:0];
    endfunction

    function automatic out_t rec_to_out(input rec_t r, input logic ch);
        out_t o;
        o.changed          = ch;
        o.neutral_count    = r.neutral;
        o.left_up_count    = r.left_up;
        o.left_down_count  = r.left_fall;
        o.right_up_count   = r.right_up;
        o.right_down_count = r.right_fall;
        o.left_min_mag     = r.left_min;
        o.left_max_mag     = r.left_max;
        o.right_min_mag    = r.right_min;
        o.right_max_mag    = r.right_max;
        o.left_mag_total   = r.left_sum;
        o.right_mag_total  = r.right_sum;
        return o;
    endfunction

    // index extension and range check
    assign in_idx_ext   = IDX_EXT_W'(item.entry_index);
    assign item_idx_ext = IDX_EXT_W'(item_reg.entry_index);
    assign item_addr    = item_idx_ext[AW-1:0];

    // captured word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg     <= item;
            range_ok_reg <= (in_idx_ext < COUNT_EXT);
        end
    end

    // clearing pass address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // statistics table, one full record per entry
    mwcs_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRY_COUNT),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.load_item),
        .rd_addr (in_idx_ext[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // step, magnitude and direction of a turn sample
    assign rec_old = rec_t'(ram_rd_data);
    assign step    = item_reg.word_value - rec_old.prior;
    assign mag     = step[15] ? (16'd0 - step) : step;
    assign step_up = (step != 16'd0) && (step < HALF_TURN);
    assign changed = range_ok_reg && (item_reg.op != OP_RESYNC)
                     && (item_reg.word_value != rec_old.prior);

    // record update
    always_comb
    begin
        rec_new       = rec_old;
        rec_new.prior = item_reg.word_value;
        if (changed)
        begin
            unique case (item_reg.op)
                OP_RESYNC:
                begin
                    rec_new.prior = item_reg.word_value;
                end
                OP_NEUTRAL:
                begin
                    rec_new.neutral = bump16(rec_old.neutral);
                end
                OP_LEFT:
                begin
                    if (step_up)
                    begin
                        rec_new.left_up = bump16(rec_old.left_up);
                    end
                    else
                    begin
                        rec_new.left_fall = bump16(rec_old.left_fall);
                    end
                    if (mag < rec_old.left_min)
                    begin
                        rec_new.left_min = mag;
                    end
                    if (mag > rec_old.left_max)
                    begin
                        rec_new.left_max = mag;
                    end
                    rec_new.left_sum = sat_add32(rec_old.left_sum, mag);
                end
                OP_RIGHT:
                begin
                    if (step_up)
                    begin
                        rec_new.right_up = bump16(rec_old.right_up);
                    end
                    else
                    begin
                        rec_new.right_fall = bump16(rec_old.right_fall);
                    end
                    if (mag < rec_old.right_min)
                    begin
                        rec_new.right_min = mag;
                    end
                    if (mag > rec_old.right_max)
                    begin
                        rec_new.right_max = mag;
                    end
                    rec_new.right_sum = sat_add32(rec_old.right_sum, mag);
                end
                default:
                begin
                    rec_new.prior = item_reg.word_value;
                end
            endcase
        end
    end

    // table write: reset record while clearing, updated record on commit of an in-range word
    assign ram_wr_en   = cmd.clear_step || (cmd.commit && range_ok_reg);
    assign ram_wr_addr = cmd.clear_step ? clr_cnt_reg : item_addr;
    assign ram_wr_data = cmd.clear_step ? REC_W'(REC_RESET) : REC_W'(rec_new);

    // out of range words report the reset statistics
    assign out_next = range_ok_reg ? rec_to_out(rec_new, changed)
                                   : rec_to_out(REC_RESET, 1'b0);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign result         = out_reg;
    assign sts.clear_last = (clr_cnt_reg == LAST_ADDR);
    assign sts.out_free   = !out_valid_reg || !result_stall;

`ifndef SYNTH
    // no commit while the table is being cleared
    a_no_commit_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit && cmd.clear_step))
        else $error("commit during clearing pass");

    // a commit never overwrites a result still waiting
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !result_stall))
        else $error("result overwritten");

    // a committed result is offered in the next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("committed result not offered");

    // an out of range word reports the reset statistics
    a_range_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !range_ok_reg) |=>
            (!result.changed && result.left_min_mag == MIN_NONE
             && result.right_min_mag == MIN_NONE && result.left_mag_total == 32'd0))
        else $error("out of range word altered statistics");

    // a resync never reports a change
    a_resync_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && item_reg.op == OP_RESYNC) |=> !result.changed)
        else $error("resync reported a change");
`endif

endmodule

`default_nettype wire

// ===== hdl/memory_word_change_statistics.sv =====
// Per-entry change statistics over a table of 16-bit memory words. After reset
// the block runs a clearing pass, one table entry per cycle, with item_stall
// held high. After that each word is accepted, which starts the table read,
// and then its entry is updated and written back once the result register is
// free. This read-modify-write of the single statistics table, whose read data
// is registered, means a new word is taken only after the last one is written
// back. A finished result waits in its own register, so the next word is
// accepted while the result is still stalled. Words whose entry_index is at or
// above ENTRY_COUNT leave the table alone and return the reset statistics.
`default_nettype none

module memory_word_change_statistics #(
    parameter int unsigned ENTRY_COUNT = 65536
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire mwcs_pkg::in_t item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output mwcs_pkg::out_t     result
);

    import mwcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    mwcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // table and update logic
    mwcs_datapath #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== bench/change_stats_checker.sv =====
// checker: predicts per-entry change statistics and compares every result word
`timescale 1ns / 1ps

module change_stats_checker #(
    parameter int unsigned ENTRY_COUNT = 65536
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire logic           item_stall,
    input  wire mwcs_pkg::in_t  item,
    input  wire logic           result_valid,
    input  wire logic           result_stall,
    input  wire mwcs_pkg::out_t result,
    output int unsigned         mismatch_count,
    output int unsigned         stats_pending,
    output int unsigned         stats_checked
);

    import mwcs_pkg::*;

    localparam int unsigned REPORT_MAX = 100;

    // statistics of one turn class (left or right) of one entry
    typedef struct packed {
        logic [15:0] up;
        logic [15:0] down;
        logic [15:0] min_mag;
        logic [15:0] max_mag;
        logic [31:0] mag_sum;
    } turn_stats_t;

    typedef struct packed {
        logic [15:0] prior;
        logic [15:0] neutral;
        turn_stats_t left_turn;
        turn_stats_t right_turn;
    } entry_stats_t;

    // entries never written read as the cleared state
    entry_stats_t stats_table [int unsigned];
    out_t         expected_stats_q [$];

    function automatic entry_stats_t cleared_entry();
        entry_stats_t e;
        e = '0;
        e.left_turn.min_mag  = MIN_NONE;
        e.right_turn.min_mag = MIN_NONE;
        return e;
    endfunction

    function automatic logic [15:0] count_up(logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    // signed modular step: up if positive, magnitude of 0x8000 is 32768
    function automatic turn_stats_t apply_step(turn_stats_t t, logic [15:0] step);
        logic [15:0] mag;
        logic [32:0] total;
        mag = step[15] ? (~step + 16'd1) : step;
        if (step != 16'd0 && !step[15])
            t.up = count_up(t.up);
        else
            t.down = count_up(t.down);
        if (mag < t.min_mag)
            t.min_mag = mag;
        if (mag > t.max_mag)
            t.max_mag = mag;
        total = {1'b0, t.mag_sum} + {17'd0, mag};
        t.mag_sum = total[32] ? SUM_MAX : total[31:0];
        return t;
    endfunction

    function automatic out_t stats_to_word(entry_stats_t e, logic changed);
        out_t r;
        r.changed          = changed;
        r.neutral_count    = e.neutral;
        r.left_up_count    = e.left_turn.up;
        r.left_down_count  = e.left_turn.down;
        r.right_up_count   = e.right_turn.up;
        r.right_down_count = e.right_turn.down;
        r.left_min_mag     = e.left_turn.min_mag;
        r.left_max_mag     = e.left_turn.max_mag;
        r.right_min_mag    = e.right_turn.min_mag;
        r.right_max_mag    = e.right_turn.max_mag;
        r.left_mag_total   = e.left_turn.mag_sum;
        r.right_mag_total  = e.right_turn.mag_sum;
        return r;
    endfunction

    // update the entry addressed by one input word and return its statistics
    function automatic out_t predict_entry_stats(in_t w);
        entry_stats_t e;
        logic         changed;
        logic [15:0]  step;
        e = cleared_entry();
        if (w.entry_index >= ENTRY_COUNT)
            return stats_to_word(e, 1'b0);
        if (stats_table.exists(w.entry_index))
            e = stats_table[w.entry_index];
        changed = (w.op != OP_RESYNC) && (w.word_value != e.prior);
        step    = w.word_value - e.prior;
        if (changed)
        begin
            case (w.op)
                OP_NEUTRAL: e.neutral    = count_up(e.neutral);
                OP_LEFT:    e.left_turn  = apply_step(e.left_turn, step);
                OP_RIGHT:   e.right_turn = apply_step(e.right_turn, step);
                default:    ;
            endcase
        end
        e.prior = w.word_value;
        stats_table[w.entry_index] = e;
        return stats_to_word(e, changed);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $error("%s: expected %0d, actual %0d", field, want, got);
            else if (mismatch_count == REPORT_MAX + 1)
                $display("further mismatch reports suppressed");
        end
    endfunction

    // compare accepted results first, then queue the prediction for a new word
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            stats_table.delete();
            expected_stats_q.delete();
            stats_pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_stats_q.size() == 0)
                begin
                    mismatch_count++;
                    $error("result word with no expected statistics waiting");
                end
                else
                begin
                    want = expected_stats_q.pop_front();
                    stats_checked++;
                    check_field("changed", 32'(want.changed), 32'(result.changed));
                    check_field("neutral_count", 32'(want.neutral_count),
                                32'(result.neutral_count));
                    check_field("left_up_count", 32'(want.left_up_count),
                                32'(result.left_up_count));
                    check_field("left_down_count", 32'(want.left_down_count),
                                32'(result.left_down_count));
                    check_field("right_up_count", 32'(want.right_up_count),
                                32'(result.right_up_count));
                    check_field("right_down_count", 32'(want.right_down_count),
                                32'(result.right_down_count));
                    check_field("left_min_mag", 32'(want.left_min_mag),
                                32'(result.left_min_mag));
                    check_field("left_max_mag", 32'(want.left_max_mag),
                                32'(result.left_max_mag));
                    check_field("right_min_mag", 32'(want.right_min_mag),
                                32'(result.right_min_mag));
                    check_field("right_max_mag", 32'(want.right_max_mag),
                                32'(result.right_max_mag));
                    check_field("left_mag_total", want.left_mag_total, result.left_mag_total);
                    check_field("right_mag_total", want.right_mag_total,
                                result.right_mag_total);
                end
            end
            if (item_valid && !item_stall)
                expected_stats_q = {expected_stats_q, predict_entry_stats(item)};
            stats_pending = expected_stats_q.size();
        end
    end

endmodule

// ===== bench/memory_word_change_statistics_tb.sv =====
// testbench top: word stimulus, result stalls and verdict for the change statistics block
`timescale 1ns / 1ps

module memory_word_change_statistics_tb;
    import mwcs_pkg::*;

    localparam int unsigned ENTRY_COUNT   = 65536;
    localparam int unsigned RANDOM_WORDS  = 1900;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_t  item;
    logic result_valid;
    logic result_stall;
    out_t result;

    int unsigned mismatch_count;
    int unsigned stats_pending;
    int unsigned stats_checked;
    int unsigned words_sent;
    bit          idle_on;

    logic [15:0] hot_entry [8];
    logic [15:0] hot_value [8];

    memory_word_change_statistics #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    change_stats_checker #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .mismatch_count (mismatch_count),
        .stats_pending  (stats_pending),
        .stats_checked  (stats_checked)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side stalls at random while idling is on
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= idle_on && ($urandom_range(99, 0) < 15);
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // offer one word, called and returning at a falling edge
    task automatic send_word(input op_t op, input logic [15:0] idx, input logic [15:0] val);
        in_t w;
        while (idle_on && $urandom_range(99, 0) < 15)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        w.op          = op;
        w.entry_index = idx;
        w.word_value  = val;
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (stats_pending != 0);
    endtask

    // random word: mostly hot entries with steps near the interesting edges
    task automatic send_random_word();
        bit          hot;
        int unsigned slot;
        int unsigned pick;
        logic [15:0] idx;
        logic [15:0] base;
        logic [15:0] delta;
        logic [15:0] val;
        op_t         op;
        hot   = $urandom_range(99, 0) < 80;
        slot  = $urandom_range(7, 0);
        idx   = hot ? hot_entry[slot] : 16'($urandom);
        base  = hot ? hot_value[slot] : 16'($urandom);
        pick  = $urandom_range(9, 0);
        delta = 16'($urandom_range(4, 1));
        case (pick)
            0, 1:    val = base;
            2, 3, 4: val = $urandom_range(1, 0) ? base + delta : base - delta;
            5:       val = base + HALF_TURN;
            6:       val = base + ($urandom_range(1, 0) ? 16'h7FFF : 16'h8001);
            default: val = 16'($urandom);
        endcase
        op = op_t'($urandom_range(3, 0));
        if (hot)
            hot_value[slot] = val;
        send_word(op, idx, val);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        idle_on    = 1'b1;
        words_sent = 0;
        hot_entry[0] = 16'h0000;
        hot_entry[1] = 16'hFFFF;
        hot_entry[2] = 16'h0005;
        for (int k = 3; k < 8; k++)
            hot_entry[k] = 16'($urandom);
        for (int k = 0; k < 8; k++)
            hot_value[k] = 16'h0000;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // resync, unchanged and changed neutral samples
        send_word(OP_RESYNC,  16'h0005, 16'h1234);
        send_word(OP_NEUTRAL, 16'h0005, 16'h1234);
        send_word(OP_NEUTRAL, 16'h0005, 16'h1235);
        // left steps: +1, -1, half turn, -32767, +32767, unchanged
        send_word(OP_LEFT,    16'h0005, 16'h1236);
        send_word(OP_LEFT,    16'h0005, 16'h1235);
        send_word(OP_LEFT,    16'h0005, 16'h9235);
        send_word(OP_LEFT,    16'h0005, 16'h1236);
        send_word(OP_LEFT,    16'h0005, 16'h9235);
        send_word(OP_LEFT,    16'h0005, 16'h9235);
        // right steps on the same entry
        send_word(OP_RIGHT,   16'h0005, 16'h1235);
        send_word(OP_RIGHT,   16'h0005, 16'h1236);
        send_word(OP_RIGHT,   16'h0005, 16'h1235);
        send_word(OP_RIGHT,   16'h0005, 16'h9234);
        send_word(OP_RESYNC,  16'h0005, 16'h0000);
        // extreme entries and values, wrap-around steps
        send_word(OP_NEUTRAL, 16'hFFFF, 16'hFFFF);
        send_word(OP_RESYNC,  16'h0000, 16'hFFFF);
        send_word(OP_LEFT,    16'h0000, 16'h0000);
        send_word(OP_RIGHT,   16'hFFFF, 16'h7FFF);
        send_word(OP_NEUTRAL, 16'h1000, 16'h0000);
        send_word(OP_LEFT,    16'h2000, 16'hFFFF);
        send_word(OP_RIGHT,   16'h2000, 16'h0000);
        wait_for_results();

        // random traffic with a stretch of no idling and one full drain
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            idle_on = !(i >= 800 && i < 1100);
            send_random_word();
            if (i == 1400)
                wait_for_results();
        end
        idle_on = 1'b1;
        wait_for_results();
        repeat (10) @(posedge clk);

        $display("covered resync, unchanged and changed samples of each class, step extremes");
        $display("and random traffic with stalls: %0d words, %0d results checked",
                 words_sent, stats_checked);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mwcs_pkg.sv
hdl/mwcs_ram.sv
hdl/mwcs_ctrl.sv
hdl/mwcs_datapath.sv
hdl/memory_word_change_statistics.sv
bench/change_stats_checker.sv
bench/memory_word_change_statistics_tb.sv
